// ===== sv/plcseq_pkg.sv =====
// Package of the scan-cycle sequencer: codes, state encodings and word types.
`timescale 1ns / 1ps

package plcseq_pkg;

    // Function codes of an input word.
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_RUN   = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;
    localparam logic [1:0] FUNC_CYCLE = 2'd3;

    // Core step outcomes.
    localparam logic [1:0] CORE_RUNNING  = 2'd0;
    localparam logic [1:0] CORE_FINISHED = 2'd1;
    localparam logic [1:0] CORE_EXCEPT   = 2'd2;

    // Command return codes.
    localparam logic [1:0] RC_ACCEPTED  = 2'd0;
    localparam logic [1:0] RC_RESUMED   = 2'd1;
    localparam logic [1:0] RC_LOAD_FAIL = 2'd2;
    localparam logic [1:0] RC_REFUSED   = 2'd3;

    // Visible run states.
    localparam logic [2:0] VS_STOP  = 3'd0;
    localparam logic [2:0] VS_RUN   = 3'd1;
    localparam logic [2:0] VS_CYCLE = 3'd2;
    localparam logic [2:0] VS_PAUSE = 3'd3;
    localparam logic [2:0] VS_EXC   = 3'd4;

    // Routine start selection.
    localparam logic [1:0] RT_NONE = 2'd0;
    localparam logic [1:0] RT_INIT = 2'd1;
    localparam logic [1:0] RT_LOOP = 2'd2;

    // Configuration port.
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic REG_CYCLE_PERIOD = 1'b0;
    localparam logic REG_LOOP_ADDR    = 1'b1;

    typedef enum logic [4:0] {
        SEQ_STOP  = 5'b00001,
        SEQ_INIT  = 5'b00010,
        SEQ_LOOP  = 5'b00100,
        SEQ_CONT  = 5'b01000,
        SEQ_PAUSE = 5'b10000
    } seq_state_t;

    // Sequencer control state passed between the top level and the step logic.
    typedef struct packed {
        seq_state_t  seq;
        logic [2:0]  vis;
    } ctl_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] now_ms;
        logic        load_ok;
        logic        input_read_error;
        logic [1:0]  core_status;
        logic        output_write_error;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  return_code;
        logic [2:0]  run_state;
        logic        notify_valid;
        logic [2:0]  notify_state;
        logic        core_reset;
        logic [1:0]  routine_select;
        logic        read_inputs;
        logic        step_core;
        logic        write_outputs;
        logic        io_to_default;
        logic [31:0] last_duration_ms;
        logic [31:0] max_duration_ms;
    } out_word_t;

endpackage

// ===== sv/plcseq_in_if.sv =====
// Input channel interface of the scan-cycle sequencer.
`timescale 1ns / 1ps

interface plcseq_in_if;
    logic                 valid;
    logic                 ready;
    plcseq_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/plcseq_out_if.sv =====
// Result channel interface of the scan-cycle sequencer.
`timescale 1ns / 1ps

interface plcseq_out_if;
    logic                  valid;
    logic                  ready;
    plcseq_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/plcseq_step.sv =====
// Next-state and result logic of the scan-cycle sequencer for one input word.
`timescale 1ns / 1ps

module plcseq_step #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  plcseq_pkg::in_word_t   item,
    input  logic [15:0]            cycle_period,
    input  plcseq_pkg::ctl_t       ctl_q,
    input  logic [TIME_WIDTH-1:0]  period_timer_q,
    input  logic [TIME_WIDTH-1:0]  loop_start_q,
    input  logic [TIME_WIDTH-1:0]  dur_q,
    input  logic [TIME_WIDTH-1:0]  dur_max_q,
    output plcseq_pkg::ctl_t       ctl_next,
    output logic [TIME_WIDTH-1:0]  period_timer_next,
    output logic [TIME_WIDTH-1:0]  loop_start_next,
    output logic [TIME_WIDTH-1:0]  dur_next,
    output logic [TIME_WIDTH-1:0]  dur_max_next,
    output plcseq_pkg::out_word_t  result
);

    logic [TIME_WIDTH-1:0] now;
    logic [TIME_WIDTH-1:0] period;
    logic [TIME_WIDTH-1:0] elapsed;

    assign now      = TIME_WIDTH'(item.now_ms);
    assign period   = TIME_WIDTH'(cycle_period);
    assign elapsed  = now - period_timer_q;

    always_comb
    begin
        logic                  do_stop;
        logic                  do_exc;
        logic                  do_done;
        logic [TIME_WIDTH-1:0] measured;

        do_stop  = 1'b0;
        do_exc   = 1'b0;
        do_done  = 1'b0;
        measured = '0;

        ctl_next          = ctl_q;
        period_timer_next = period_timer_q;
        loop_start_next   = loop_start_q;
        dur_next          = dur_q;
        dur_max_next      = dur_max_q;
        result            = '0;

        if (item.func == plcseq_pkg::FUNC_TICK)
        begin
            case (ctl_q.seq)
                plcseq_pkg::SEQ_INIT:
                begin
                    if (ctl_q.vis == plcseq_pkg::VS_STOP)
                    begin
                        do_stop = 1'b1;
                    end
                    else
                    begin
                        result.read_inputs = 1'b1;
                        if (item.input_read_error)
                        begin
                            do_exc = 1'b1;
                        end
                        else
                        begin
                            result.step_core = 1'b1;
                            if (item.core_status == plcseq_pkg::CORE_FINISHED)
                            begin
                                result.write_outputs = 1'b1;
                                if (item.output_write_error)
                                    do_exc = 1'b1;
                                else
                                    ctl_next.seq = plcseq_pkg::SEQ_LOOP;
                            end
                            else if (item.core_status == plcseq_pkg::CORE_EXCEPT)
                            begin
                                do_exc = 1'b1;
                            end
                        end
                    end
                end
                plcseq_pkg::SEQ_LOOP:
                begin
                    if (ctl_q.vis == plcseq_pkg::VS_STOP)
                    begin
                        do_stop = 1'b1;
                    end
                    else if (elapsed >= period)
                    begin
                        period_timer_next     = period_timer_q + period;
                        loop_start_next       = now;
                        result.routine_select = plcseq_pkg::RT_LOOP;
                        result.read_inputs    = 1'b1;
                        if (item.input_read_error)
                        begin
                            do_exc = 1'b1;
                        end
                        else
                        begin
                            result.step_core = 1'b1;
                            if (item.core_status == plcseq_pkg::CORE_RUNNING)
                            begin
                                ctl_next.seq = plcseq_pkg::SEQ_CONT;
                            end
                            else if (item.core_status == plcseq_pkg::CORE_FINISHED)
                            begin
                                result.write_outputs = 1'b1;
                                if (item.output_write_error)
                                    do_exc = 1'b1;
                                else
                                    do_done = 1'b1;
                            end
                            else if (item.core_status == plcseq_pkg::CORE_EXCEPT)
                            begin
                                do_exc = 1'b1;
                            end
                        end
                    end
                end
                plcseq_pkg::SEQ_CONT:
                begin
                    if (ctl_q.vis == plcseq_pkg::VS_STOP)
                    begin
                        do_stop = 1'b1;
                    end
                    else
                    begin
                        result.step_core = 1'b1;
                        if (item.core_status == plcseq_pkg::CORE_FINISHED)
                        begin
                            result.write_outputs = 1'b1;
                            if (item.output_write_error)
                                do_exc = 1'b1;
                            else
                                do_done = 1'b1;
                        end
                        else if (item.core_status == plcseq_pkg::CORE_EXCEPT)
                        begin
                            do_exc = 1'b1;
                        end
                    end
                end
                plcseq_pkg::SEQ_PAUSE:
                begin
                    if (ctl_q.vis == plcseq_pkg::VS_STOP)
                    begin
                        do_stop = 1'b1;
                    end
                    else if (ctl_q.vis == plcseq_pkg::VS_RUN ||
                             ctl_q.vis == plcseq_pkg::VS_CYCLE)
                    begin
                        result.notify_valid = 1'b1;
                        result.notify_state = ctl_q.vis;
                        ctl_next.seq        = plcseq_pkg::SEQ_LOOP;
                    end
                end
                default:
                begin
                    ctl_next.seq = plcseq_pkg::SEQ_STOP;
                    if (ctl_q.vis == plcseq_pkg::VS_RUN ||
                        ctl_q.vis == plcseq_pkg::VS_CYCLE)
                    begin
                        result.core_reset     = 1'b1;
                        result.routine_select = plcseq_pkg::RT_INIT;
                        dur_next              = '0;
                        dur_max_next          = '0;
                        result.notify_valid   = 1'b1;
                        result.notify_state   = plcseq_pkg::VS_RUN;
                        ctl_next.seq          = plcseq_pkg::SEQ_INIT;
                    end
                end
            endcase

            if (do_stop)
            begin
                result.io_to_default = 1'b1;
                result.notify_valid  = 1'b1;
                result.notify_state  = plcseq_pkg::VS_STOP;
                ctl_next.seq         = plcseq_pkg::SEQ_STOP;
            end

            if (do_exc)
            begin
                result.io_to_default = 1'b1;
                result.notify_valid  = 1'b1;
                result.notify_state  = plcseq_pkg::VS_EXC;
                ctl_next.vis         = plcseq_pkg::VS_EXC;
                ctl_next.seq         = plcseq_pkg::SEQ_STOP;
            end

            if (do_done)
            begin
                // A loop that starts and finishes on the same tick measures from this tick.
                measured = now - loop_start_next;
                dur_next = measured;
                if (measured > dur_max_q)
                    dur_max_next = measured;
                if (ctl_q.vis == plcseq_pkg::VS_CYCLE)
                begin
                    result.notify_valid = 1'b1;
                    result.notify_state = plcseq_pkg::VS_PAUSE;
                    ctl_next.vis        = plcseq_pkg::VS_PAUSE;
                    ctl_next.seq        = plcseq_pkg::SEQ_PAUSE;
                end
                else
                begin
                    ctl_next.seq = plcseq_pkg::SEQ_LOOP;
                end
            end
        end
        else if (item.func == plcseq_pkg::FUNC_STOP)
        begin
            ctl_next.vis = plcseq_pkg::VS_STOP;
        end
        else if (ctl_q.seq == plcseq_pkg::SEQ_STOP && !item.load_ok)
        begin
            result.return_code = plcseq_pkg::RC_LOAD_FAIL;
        end
        else if (item.func == plcseq_pkg::FUNC_CYCLE)
        begin
            ctl_next.vis = plcseq_pkg::VS_CYCLE;
        end
        else if (ctl_q.seq == plcseq_pkg::SEQ_STOP)
        begin
            ctl_next.vis = plcseq_pkg::VS_RUN;
        end
        else if (ctl_q.seq == plcseq_pkg::SEQ_PAUSE)
        begin
            ctl_next.vis       = plcseq_pkg::VS_RUN;
            result.return_code = plcseq_pkg::RC_RESUMED;
        end
        else
        begin
            result.return_code = plcseq_pkg::RC_REFUSED;
        end

        result.run_state        = ctl_next.vis;
        result.last_duration_ms = 32'(dur_next);
        result.max_duration_ms  = 32'(dur_max_next);
    end

endmodule

// ===== sv/plc_scan_cycle_sequencer_core.sv =====
// Top level of the scan-cycle sequencer: state registers, result register and APB registers.
`timescale 1ns / 1ps

// The sequencer takes one word per cycle on in_ch while in_ch.ready is high:
// a run, stop or single-cycle command, or a process tick that carries the
// millisecond time and the outcomes of the input read, the core step and the
// output write. For every word it returns exactly one result word on out_ch
// with the command's return code, the visible run state, an optional
// state-change notification, the core and I/O actions for this tick and the
// loop duration statistics. The result of a word accepted at one edge is
// registered and presented from the next edge on; the sequencer state and
// the result register are both written at the accept edge, so the next word
// already sees the updated state. in_ch.ready is high whenever the result
// register is empty or being emptied in the same cycle, so a stalled receiver
// holds the pending result and stops further words only while it stalls.
// The APB port holds the cycle period (address 0, reset 10 ms) and the loop
// routine address (address 4, reset 0); both should be written while the
// sequencer is idle. Reset puts the sequencer in stop, clears the timer and
// the duration statistics and empties the result register.

module plc_scan_cycle_sequencer_core #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    plcseq_in_if.sink                         in_ch,
    plcseq_out_if.source                      out_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [plcseq_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [15:0]            cycle_period_reg;
    logic [31:0]            loop_addr_reg;

    plcseq_pkg::ctl_t       ctl_reg;
    plcseq_pkg::ctl_t       ctl_next;
    logic [TIME_WIDTH-1:0]  period_timer_reg;
    logic [TIME_WIDTH-1:0]  period_timer_next;
    logic [TIME_WIDTH-1:0]  loop_start_reg;
    logic [TIME_WIDTH-1:0]  loop_start_next;
    logic [TIME_WIDTH-1:0]  dur_reg;
    logic [TIME_WIDTH-1:0]  dur_next;
    logic [TIME_WIDTH-1:0]  dur_max_reg;
    logic [TIME_WIDTH-1:0]  dur_max_next;

    plcseq_pkg::out_word_t  result;
    plcseq_pkg::out_word_t  out_data_reg;
    logic                   out_valid_reg;

    logic                   in_accept;
    logic                   cfg_write;
    logic                   reg_sel;

    // The register index is the word address; byte offsets are ignored.
    assign reg_sel   = paddr[2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (reg_sel)
            plcseq_pkg::REG_CYCLE_PERIOD: prdata = {16'd0, cycle_period_reg};
            plcseq_pkg::REG_LOOP_ADDR:    prdata = loop_addr_reg;
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_period_reg <= 16'd10;
            loop_addr_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                plcseq_pkg::REG_CYCLE_PERIOD: cycle_period_reg <= pwdata[15:0];
                plcseq_pkg::REG_LOOP_ADDR:    loop_addr_reg    <= pwdata;
                default:                      ;
            endcase
        end
    end

    // A new word is taken whenever the result register is free or drains now.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_accept   = in_ch.valid && in_ch.ready;

    plcseq_step #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_step (
        .item              (in_ch.data),
        .cycle_period      (cycle_period_reg),
        .ctl_q             (ctl_reg),
        .period_timer_q    (period_timer_reg),
        .loop_start_q      (loop_start_reg),
        .dur_q             (dur_reg),
        .dur_max_q         (dur_max_reg),
        .ctl_next          (ctl_next),
        .period_timer_next (period_timer_next),
        .loop_start_next   (loop_start_next),
        .dur_next          (dur_next),
        .dur_max_next      (dur_max_next),
        .result            (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.seq      <= plcseq_pkg::SEQ_STOP;
            ctl_reg.vis      <= plcseq_pkg::VS_STOP;
            period_timer_reg <= '0;
            loop_start_reg   <= '0;
            dur_reg          <= '0;
            dur_max_reg      <= '0;
        end
        else if (in_accept)
        begin
            ctl_reg          <= ctl_next;
            period_timer_reg <= period_timer_next;
            loop_start_reg   <= loop_start_next;
            dur_reg          <= dur_next;
            dur_max_reg      <= dur_max_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= result;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the scan-cycle sequencer with its own prediction of every result.
`timescale 1ns / 1ps

// The testbench drives command and process-tick words into the sequencer and
// predicts each result word from its own copy of the sequencer state. A
// directed sequence walks through load failures, refused and resumed runs,
// the init routine, loop starts and waits, single cycles that end in pause,
// status three on the core, three failure paths and a stop during init. The
// random part then runs mostly well-formed traffic over several phases.
// The ticks in that traffic carry a slowly advancing millisecond time, so
// loops both wait for their period and start, with rare time jumps as noise.
// Each phase has its own cycle period, loop address and idling pattern.

module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    // Core status that is neither running, finished nor exception.
    localparam logic [1:0] CORE_OTHER = 2'd3;

    logic clk;
    logic rst_n;

    plcseq_in_if  in_ch ();
    plcseq_out_if out_ch ();

    logic                              psel    = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite  = 1'b0;
    logic [plcseq_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [31:0]                       pwdata  = '0;
    logic [31:0]                       prdata;
    logic                              pready;
    logic [31:0]                       apb_rdata = '0;

    plc_scan_cycle_sequencer_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Words waiting to be offered, and results still owed by the sequencer.
    plcseq_pkg::in_word_t  pending_words[$];
    plcseq_pkg::out_word_t expected_results[$];

    int words_queued = 0;
    int words_taken  = 0;
    int mismatches   = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int stall_left   = 0;
    logic hold_req   = 1'b0;
    logic hold_ack   = 1'b0;
    logic in_taken   = 1'b0;

    // Millisecond time carried by the well-formed ticks of the random traffic.
    logic [31:0] sim_ms = '0;

    // Predicted sequencer state, reset values as after the one reset.
    plcseq_pkg::seq_state_t mdl_seq      = plcseq_pkg::SEQ_STOP;
    logic [2:0]             mdl_vis      = plcseq_pkg::VS_STOP;
    logic [31:0]            mdl_timer    = '0;
    logic [31:0]            mdl_loop_t0  = '0;
    logic [31:0]            mdl_last_dur = '0;
    logic [31:0]            mdl_max_dur  = '0;
    logic [15:0]            mdl_period   = 16'd10;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // A watchdog: a correct run ends long before it runs out.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[plc_scan_cycle_sequencer_core] ERROR");
        $finish;
    end

    function automatic void announce(inout plcseq_pkg::out_word_t r, input logic [2:0] s);
        r.notify_valid = 1'b1;
        r.notify_state = s;
    endfunction

    // A stop request seen by the sequencer: safe I/O, stop notified.
    function automatic void halt_to_stop(inout plcseq_pkg::out_word_t r);
        r.io_to_default = 1'b1;
        announce(r, plcseq_pkg::VS_STOP);
        mdl_seq = plcseq_pkg::SEQ_STOP;
    endfunction

    // Any failure on a tick: safe I/O, exception notified and made visible.
    function automatic void fault(inout plcseq_pkg::out_word_t r);
        r.io_to_default = 1'b1;
        announce(r, plcseq_pkg::VS_EXC);
        mdl_vis = plcseq_pkg::VS_EXC;
        mdl_seq = plcseq_pkg::SEQ_STOP;
    endfunction

    // Core step outcome inside a loop. A finished loop with its outputs
    // written is measured; in single-cycle mode it then parks in pause.
    function automatic void loop_outcome(input plcseq_pkg::in_word_t w,
                                         inout plcseq_pkg::out_word_t r);
        r.step_core = 1'b1;
        if (w.core_status == plcseq_pkg::CORE_RUNNING)
        begin
            mdl_seq = plcseq_pkg::SEQ_CONT;
        end
        else if (w.core_status == plcseq_pkg::CORE_FINISHED)
        begin
            r.write_outputs = 1'b1;
            if (w.output_write_error)
            begin
                fault(r);
            end
            else
            begin
                mdl_last_dur = w.now_ms - mdl_loop_t0;
                if (mdl_last_dur > mdl_max_dur)
                    mdl_max_dur = mdl_last_dur;
                if (mdl_vis == plcseq_pkg::VS_CYCLE)
                begin
                    announce(r, plcseq_pkg::VS_PAUSE);
                    mdl_vis = plcseq_pkg::VS_PAUSE;
                    mdl_seq = plcseq_pkg::SEQ_PAUSE;
                end
                else
                begin
                    mdl_seq = plcseq_pkg::SEQ_LOOP;
                end
            end
        end
        else if (w.core_status == plcseq_pkg::CORE_EXCEPT)
        begin
            fault(r);
        end
    endfunction

    // Works out the result of one accepted word and advances the predicted state.
    function automatic plcseq_pkg::out_word_t next_scan_result(input plcseq_pkg::in_word_t w);
        plcseq_pkg::out_word_t r;
        logic [31:0]           since;
        r = '0;
        if (w.func == plcseq_pkg::FUNC_TICK)
        begin
            case (mdl_seq)
                plcseq_pkg::SEQ_INIT:
                begin
                    if (mdl_vis == plcseq_pkg::VS_STOP)
                    begin
                        halt_to_stop(r);
                    end
                    else
                    begin
                        r.read_inputs = 1'b1;
                        if (w.input_read_error)
                        begin
                            fault(r);
                        end
                        else
                        begin
                            // The init routine runs on until it finishes.
                            r.step_core = 1'b1;
                            if (w.core_status == plcseq_pkg::CORE_FINISHED)
                            begin
                                r.write_outputs = 1'b1;
                                if (w.output_write_error)
                                    fault(r);
                                else
                                    mdl_seq = plcseq_pkg::SEQ_LOOP;
                            end
                            else if (w.core_status == plcseq_pkg::CORE_EXCEPT)
                            begin
                                fault(r);
                            end
                        end
                    end
                end
                plcseq_pkg::SEQ_LOOP:
                begin
                    since = w.now_ms - mdl_timer;
                    if (mdl_vis == plcseq_pkg::VS_STOP)
                    begin
                        halt_to_stop(r);
                    end
                    else if (since >= {16'd0, mdl_period})
                    begin
                        // The period timer advances by whole periods, so a late
                        // loop start is caught up on the following ticks.
                        mdl_timer = mdl_timer + {16'd0, mdl_period};
                        r.routine_select = plcseq_pkg::RT_LOOP;
                        mdl_loop_t0 = w.now_ms;
                        r.read_inputs = 1'b1;
                        if (w.input_read_error)
                            fault(r);
                        else
                            loop_outcome(w, r);
                        // Status three on a fresh start leaves the state in loop,
                        // so the next start waits for the next period.
                        if (mdl_seq == plcseq_pkg::SEQ_CONT &&
                            w.core_status != plcseq_pkg::CORE_RUNNING)
                            mdl_seq = plcseq_pkg::SEQ_LOOP;
                    end
                end
                plcseq_pkg::SEQ_CONT:
                begin
                    if (mdl_vis == plcseq_pkg::VS_STOP)
                        halt_to_stop(r);
                    else
                        loop_outcome(w, r);
                end
                plcseq_pkg::SEQ_PAUSE:
                begin
                    if (mdl_vis == plcseq_pkg::VS_STOP)
                    begin
                        halt_to_stop(r);
                    end
                    else if (mdl_vis == plcseq_pkg::VS_RUN || mdl_vis == plcseq_pkg::VS_CYCLE)
                    begin
                        announce(r, mdl_vis);
                        mdl_seq = plcseq_pkg::SEQ_LOOP;
                    end
                end
                default:
                begin
                    mdl_seq = plcseq_pkg::SEQ_STOP;
                    if (mdl_vis == plcseq_pkg::VS_RUN || mdl_vis == plcseq_pkg::VS_CYCLE)
                    begin
                        // A start always reports run, even for a single cycle.
                        r.core_reset = 1'b1;
                        r.routine_select = plcseq_pkg::RT_INIT;
                        mdl_last_dur = '0;
                        mdl_max_dur = '0;
                        announce(r, plcseq_pkg::VS_RUN);
                        mdl_seq = plcseq_pkg::SEQ_INIT;
                    end
                end
            endcase
        end
        else if (w.func == plcseq_pkg::FUNC_STOP)
        begin
            mdl_vis = plcseq_pkg::VS_STOP;
        end
        else if (mdl_seq == plcseq_pkg::SEQ_STOP && !w.load_ok)
        begin
            r.return_code = plcseq_pkg::RC_LOAD_FAIL;
        end
        else if (w.func == plcseq_pkg::FUNC_CYCLE)
        begin
            mdl_vis = plcseq_pkg::VS_CYCLE;
        end
        else if (mdl_seq == plcseq_pkg::SEQ_STOP)
        begin
            mdl_vis = plcseq_pkg::VS_RUN;
        end
        else if (mdl_seq == plcseq_pkg::SEQ_PAUSE)
        begin
            mdl_vis = plcseq_pkg::VS_RUN;
            r.return_code = plcseq_pkg::RC_RESUMED;
        end
        else
        begin
            r.return_code = plcseq_pkg::RC_REFUSED;
        end
        r.run_state = mdl_vis;
        r.last_duration_ms = mdl_last_dur;
        r.max_duration_ms = mdl_max_dur;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Driver: a new word goes out at the falling edge once the previous one
    // was taken, unless the sender idles in this cycle.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else if (!in_ch.valid || in_taken)
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                in_ch.data  <= pending_words.pop_front();
                in_ch.valid <= 1'b1;
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or one long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack     <= hold_req;
            stall_left   <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Monitor: checks each result word against the oldest expectation, then
    // predicts the word accepted at this edge. Its result is registered and comes
    // at the next edge at the earliest, so the order of the two steps is safe.
    always @(posedge clk)
    begin
        plcseq_pkg::out_word_t want;
        if (psel && penable && !pwrite)
            apb_rdata <= prdata;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with no expectation waiting");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("return_code", want.return_code, out_ch.data.return_code);
                    check_field("run_state", want.run_state, out_ch.data.run_state);
                    check_field("notify_valid", want.notify_valid, out_ch.data.notify_valid);
                    check_field("notify_state", want.notify_state, out_ch.data.notify_state);
                    check_field("core_reset", want.core_reset, out_ch.data.core_reset);
                    check_field("routine_select", want.routine_select,
                                out_ch.data.routine_select);
                    check_field("read_inputs", want.read_inputs, out_ch.data.read_inputs);
                    check_field("step_core", want.step_core, out_ch.data.step_core);
                    check_field("write_outputs", want.write_outputs, out_ch.data.write_outputs);
                    check_field("io_to_default", want.io_to_default, out_ch.data.io_to_default);
                    check_field("last_duration_ms", want.last_duration_ms,
                                out_ch.data.last_duration_ms);
                    check_field("max_duration_ms", want.max_duration_ms,
                                out_ch.data.max_duration_ms);
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                expected_results.push_back(next_scan_result(in_ch.data));
                words_taken++;
            end
            in_taken <= in_ch.valid && in_ch.ready;
        end
    end

    task automatic queue_word(input logic [1:0] func, input logic [31:0] now,
                              input logic load, input logic rd_err,
                              input logic [1:0] status, input logic wr_err);
        plcseq_pkg::in_word_t w;
        w.func               = func;
        w.now_ms             = now;
        w.load_ok            = load;
        w.input_read_error   = rd_err;
        w.core_status        = status;
        w.output_write_error = wr_err;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Random traffic: mostly ticks with advancing time, commands now and then,
    // rare failures and rare time jumps.
    task automatic queue_traffic(input int count);
        plcseq_pkg::in_word_t w;
        logic [63:0]          noise;
        int                   pick;
        int                   step_max;
        for (int n = 0; n < count; n++)
        begin
            noise = {$urandom, $urandom};
            w = noise[$bits(plcseq_pkg::in_word_t)-1:0];
            pick = $urandom_range(99);
            if (pick < 6)
                w.func = plcseq_pkg::FUNC_RUN;
            else if (pick < 9)
                w.func = plcseq_pkg::FUNC_CYCLE;
            else if (pick < 11)
                w.func = plcseq_pkg::FUNC_STOP;
            else
                w.func = plcseq_pkg::FUNC_TICK;
            if (w.func == plcseq_pkg::FUNC_TICK)
            begin
                // Steps of up to a third of the period let the loop both wait
                // and catch up with its timer.
                step_max = (mdl_period < 3) ? 1 : mdl_period / 3;
                if ($urandom_range(99) >= 3)
                begin
                    sim_ms = sim_ms + $urandom_range(step_max);
                    w.now_ms = sim_ms;
                end
                w.input_read_error = ($urandom_range(99) < 2);
                w.output_write_error = ($urandom_range(99) < 2);
                pick = $urandom_range(99);
                if (pick < 3)
                    w.core_status = plcseq_pkg::CORE_EXCEPT;
                else if (pick < 13)
                    w.core_status = CORE_OTHER;
                else if (pick < 50)
                    w.core_status = plcseq_pkg::CORE_RUNNING;
                else
                    w.core_status = plcseq_pkg::CORE_FINISHED;
            end
            else
            begin
                w.load_ok = ($urandom_range(99) < 85);
            end
            pending_words.push_back(w);
            words_queued++;
        end
    endtask

    // Waits until every queued word is taken and its result checked, then lets
    // the registered result path settle.
    task automatic wait_results_done();
        while (words_taken != words_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // APB write then read-back of one register; the sequencer must be idle.
    task automatic program_register(input logic idx, input logic [31:0] value);
        logic [31:0] want;
        want = (idx == plcseq_pkg::REG_CYCLE_PERIOD) ? {16'd0, value[15:0]} : value;
        for (int rd = 0; rd < 2; rd++)
        begin
            @(negedge clk);
            psel    = 1'b1;
            penable = 1'b0;
            pwrite  = (rd == 0);
            paddr   = {idx, 2'b00};
            pwdata  = value;
            @(negedge clk);
            penable = 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            @(negedge clk);
            psel    = 1'b0;
            penable = 1'b0;
            pwrite  = 1'b0;
        end
        check_field(idx == plcseq_pkg::REG_CYCLE_PERIOD ? "cycle_period_ms"
                                                        : "loop_routine_address",
                    want, apb_rdata);
        if (idx == plcseq_pkg::REG_CYCLE_PERIOD)
            mdl_period = value[15:0];
    endtask

    task automatic start_phase(input int tx, input int rx, input logic [15:0] period,
                               input logic [31:0] addr);
        wait_results_done();
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
        program_register(plcseq_pkg::REG_CYCLE_PERIOD, period);
        program_register(plcseq_pkg::REG_LOOP_ADDR, addr);
        sim_ms = mdl_timer;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed walk with the reset period of 10 ms.
        queue_word(plcseq_pkg::FUNC_RUN,   32'd0, 1'b0, 1'b0,
                   plcseq_pkg::CORE_RUNNING, 1'b0);                    // load failed
        queue_word(plcseq_pkg::FUNC_CYCLE, 32'd0, 1'b0, 1'b0,
                   plcseq_pkg::CORE_RUNNING, 1'b0);                    // load failed
        queue_word(plcseq_pkg::FUNC_RUN,   32'd0, 1'b1, 1'b0,
                   plcseq_pkg::CORE_RUNNING, 1'b0);
        queue_word(plcseq_pkg::FUNC_TICK,  32'd0, 1'b0, 1'b0,
                   plcseq_pkg::CORE_RUNNING, 1'b0);                    // start, init
        queue_word(plcseq_pkg::FUNC_RUN,   32'd0, 1'b1, 1'b0,
                   plcseq_pkg::CORE_RUNNING, 1'b0);                    // refused
        queue_word(plcseq_pkg::FUNC_TICK,  32'd0, 1'b0, 1'b0, CORE_OTHER, 1'b0); // init goes on
        queue_word(plcseq_pkg::FUNC_TICK,  32'd1, 1'b0, 1'b0,
                   plcseq_pkg::CORE_FINISHED, 1'b0);
        queue_word(plcseq_pkg::FUNC_TICK,  32'd9, 1'b0, 1'b0,
                   plcseq_pkg::CORE_FINISHED, 1'b0);                   // not yet due
        queue_word(plcseq_pkg::FUNC_TICK,  32'd10, 1'b0, 1'b0,
                   plcseq_pkg::CORE_RUNNING, 1'b0);                    // loop start
        queue_word(plcseq_pkg::FUNC_TICK,  32'd13, 1'b0, 1'b0, CORE_OTHER, 1'b0); // loop goes on
        queue_word(plcseq_pkg::FUNC_TICK,  32'd14, 1'b0, 1'b0,
                   plcseq_pkg::CORE_FINISHED, 1'b0);
        queue_word(plcseq_pkg::FUNC_CYCLE, 32'd0, 1'b0, 1'b0,
                   plcseq_pkg::CORE_RUNNING, 1'b0);                    // no load check
        queue_word(plcseq_pkg::FUNC_TICK,  32'd20, 1'b0, 1'b0, CORE_OTHER, 1'b0); // loop starts
        queue_word(plcseq_pkg::FUNC_TICK,  32'd30, 1'b0, 1'b0,
                   plcseq_pkg::CORE_FINISHED, 1'b0);                   // into pause
        queue_word(plcseq_pkg::FUNC_CYCLE, 32'd0, 1'b1, 1'b0,
                   plcseq_pkg::CORE_RUNNING, 1'b0);
        queue_word(plcseq_pkg::FUNC_TICK,  32'd31, 1'b0, 1'b0,
                   plcseq_pkg::CORE_RUNNING, 1'b0);                    // leaves pause
        queue_word(plcseq_pkg::FUNC_TICK,  32'd40, 1'b0, 1'b0,
                   plcseq_pkg::CORE_FINISHED, 1'b0);
        queue_word(plcseq_pkg::FUNC_RUN,   32'd0, 1'b0, 1'b0,
                   plcseq_pkg::CORE_RUNNING, 1'b0);                    // resumed
        queue_word(plcseq_pkg::FUNC_TICK,  32'd41, 1'b0, 1'b0,
                   plcseq_pkg::CORE_RUNNING, 1'b0);
        queue_word(plcseq_pkg::FUNC_TICK,  32'hFFFF_FFFF, 1'b0, 1'b1,
                   plcseq_pkg::CORE_FINISHED, 1'b0);
        queue_word(plcseq_pkg::FUNC_RUN,   32'd0, 1'b1, 1'b0,
                   plcseq_pkg::CORE_RUNNING, 1'b0);
        queue_word(plcseq_pkg::FUNC_TICK,  32'd60, 1'b1, 1'b0,
                   plcseq_pkg::CORE_RUNNING, 1'b0);
        queue_word(plcseq_pkg::FUNC_TICK,  32'd61, 1'b1, 1'b0,
                   plcseq_pkg::CORE_EXCEPT, 1'b0);                     // core exception
        queue_word(plcseq_pkg::FUNC_CYCLE, 32'd0, 1'b1, 1'b0,
                   plcseq_pkg::CORE_RUNNING, 1'b0);                    // start as run
        queue_word(plcseq_pkg::FUNC_TICK,  32'd62, 1'b1, 1'b0,
                   plcseq_pkg::CORE_RUNNING, 1'b0);
        queue_word(plcseq_pkg::FUNC_TICK,  32'd63, 1'b1, 1'b0,
                   plcseq_pkg::CORE_FINISHED, 1'b1);                   // write error
        queue_word(plcseq_pkg::FUNC_RUN,   32'd0, 1'b1, 1'b0,
                   plcseq_pkg::CORE_RUNNING, 1'b0);
        queue_word(plcseq_pkg::FUNC_TICK,  32'd64, 1'b1, 1'b1,
                   plcseq_pkg::CORE_EXCEPT, 1'b1);
        queue_word(plcseq_pkg::FUNC_STOP,  32'd0, 1'b1, 1'b1,
                   plcseq_pkg::CORE_EXCEPT, 1'b1);
        queue_word(plcseq_pkg::FUNC_TICK,  32'd65, 1'b1, 1'b1,
                   plcseq_pkg::CORE_EXCEPT, 1'b1);                     // stop in init

        // No idling at all.
        start_phase(0, 0, 16'd10, $urandom);
        queue_traffic(220);

        // Sender idle, zero period: a loop is due on every tick.
        start_phase(55, 0, 16'd0, 32'd0);
        queue_traffic(220);

        // Receiver stalling, longest period.
        start_phase(0, 55, 16'hFFFF, 32'hFFFF_FFFF);
        queue_traffic(220);

        // Both idle; halfway the sender pauses until every result is back.
        start_phase(24, 24, 16'd1, $urandom);
        queue_traffic(100);
        wait_results_done();
        sim_ms = mdl_timer;
        queue_traffic(120);

        // The receiver holds off for a long stretch while the sender keeps
        // offering words, so the result register fills and the input stalls.
        start_phase(0, 0, 16'($urandom_range(2, 40)), $urandom);
        queue_traffic(60);
        hold_req = ~hold_req;
        queue_traffic(170);

        start_phase(24, 24, 16'($urandom_range(65535)), $urandom);
        queue_traffic(200);

        wait_results_done();
        if (mismatches == 0)
            $display("[plc_scan_cycle_sequencer_core] OK");
        else
            $display("[plc_scan_cycle_sequencer_core] ERROR");
        $finish;
    end
endmodule
